// ===== rtl/fpks_pkg.sv =====
// Shared types and constants of the framed packet sender.
package fpks_pkg;

  localparam int unsigned MAX_RESULTS = 7;
  localparam int unsigned HDR_BYTES   = 5;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned CFG_IDX_W   = 8;

  localparam logic [7:0] SYNC_FIRST_RESET  = 8'hB1;
  localparam logic [7:0] SYNC_SECOND_RESET = 8'h75;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = CFG_IDX_W'(1);

  typedef enum logic {
    OP_START   = 1'b0,
    OP_PAYLOAD = 1'b1
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  channel_id;
    logic [15:0] frame_length;
    logic [7:0]  payload_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]  sum_a;
    logic [7:0]  sum_b;
    logic [15:0] bytes_remaining;
    logic        frame_open;
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0]             count;
    logic [MAX_RESULTS-1:0][7:0]  bytes;
    logic                         trailer;
  } result_t;

endpackage

// ===== rtl/fpks_calc.sv =====
// Per-item framing and checksum logic: result bytes and next state.
module fpks_calc import fpks_pkg::*; (
  input  item_t      item,
  input  state_t     st,
  input  logic [7:0] sync_first,
  input  logic [7:0] sync_second,
  output result_t    res,
  output state_t     st_nxt
);

  always_comb begin
    logic [7:0]                 a;
    logic [7:0]                 b;
    logic [HDR_BYTES-1:0][7:0]  hdr;
    logic [15:0]                rem_dec;
    res     = '0;
    st_nxt  = st;
    a       = st.sum_a;
    b       = st.sum_b;
    rem_dec = st.bytes_remaining - 16'd1;
    hdr[0]  = sync_first;
    hdr[1]  = sync_second;
    hdr[2]  = item.channel_id;
    hdr[3]  = item.frame_length[15:8];
    hdr[4]  = item.frame_length[7:0];
    if (item.op == OP_START) begin
      a = 8'd0;
      b = 8'd0;
      for (int i = 0; i < HDR_BYTES; i++) begin
        a = a + hdr[i];
        b = b + a;
        res.bytes[i] = hdr[i];
      end
      st_nxt.sum_a = a;
      st_nxt.sum_b = b;
      if (item.frame_length == 16'd0) begin
        res.bytes[HDR_BYTES]     = a;
        res.bytes[HDR_BYTES + 1] = b;
        res.count                = CNT_W'(HDR_BYTES + 2);
        res.trailer              = 1'b1;
        st_nxt.frame_open        = 1'b0;
        st_nxt.bytes_remaining   = 16'd0;
      end else begin
        res.count              = CNT_W'(HDR_BYTES);
        st_nxt.frame_open      = 1'b1;
        st_nxt.bytes_remaining = item.frame_length;
      end
    end else if (st.frame_open && (st.bytes_remaining != 16'd0)) begin
      a = st.sum_a + item.payload_byte;
      b = st.sum_b + a;
      res.bytes[0]           = item.payload_byte;
      st_nxt.sum_a           = a;
      st_nxt.sum_b           = b;
      st_nxt.bytes_remaining = rem_dec;
      if (rem_dec == 16'd0) begin
        res.bytes[1]      = a;
        res.bytes[2]      = b;
        res.count         = CNT_W'(3);
        res.trailer       = 1'b1;
        st_nxt.frame_open = 1'b0;
      end else begin
        res.count = CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/fletcher_framed_packet_sender.sv =====
// Top level of the framed packet sender with a two-byte Fletcher-style trailer (8-bit sums modulo 256).
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid / in_ready    | in_op, in_channel_id, in_frame_length,
//          |                        | in_payload_byte
//  out     | out_valid / out_ready  | out_byte, out_run_last, out_frame_end
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Each item waits in the input register, then its 0 to 7 result bytes load into a
// shift buffer that sends one byte per cycle while out_ready is high; a payload item
// gives 1 result byte, or 3 with the trailer, a start item 5 or 7, and an item with
// no result none. Reset clears the sums, the frame state, the input register's valid
// flag and the shift buffer's count, and restores the sync bytes. A stalled output
// holds its byte; the single-entry input register takes one item, then drops in_ready.
module fletcher_framed_packet_sender import fpks_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic [7:0]           in_channel_id,
  input  logic [15:0]          in_frame_length,
  input  logic [7:0]           in_payload_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_run_last,
  output logic                 out_frame_end,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic                        hold_valid_r;
  item_t                       item_r;
  state_t                      st_r;
  state_t                      st_nxt;
  result_t                     res;
  logic [7:0]                  sync_first_r;
  logic [7:0]                  sync_second_r;
  logic [MAX_RESULTS-1:0][7:0] buf_r;
  logic [MAX_RESULTS-1:0][7:0] buf_nxt;
  logic [CNT_W-1:0]            cnt_r;
  logic [CNT_W-1:0]            cnt_nxt;
  logic                        trl_r;
  logic                        trl_nxt;
  logic                        last;
  logic                        out_xfer;
  logic                        load;

  fpks_calc u_calc (
    .item        (item_r),
    .st          (st_r),
    .sync_first  (sync_first_r),
    .sync_second (sync_second_r),
    .res         (res),
    .st_nxt      (st_nxt)
  );

  assign out_valid     = (cnt_r != '0);
  assign last          = (cnt_r == CNT_W'(1));
  assign out_xfer      = out_valid && out_ready;
  assign load          = hold_valid_r && (!out_valid || (out_xfer && last));
  assign in_ready      = !hold_valid_r || load;
  assign cfg_ready     = 1'b1;
  assign out_byte      = buf_r[0];
  assign out_run_last  = last;
  assign out_frame_end = last && trl_r;

  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    trl_nxt = trl_r;
    if (load) begin
      buf_nxt = res.bytes;
      cnt_nxt = res.count;
      trl_nxt = res.trailer;
    end else if (out_xfer) begin
      buf_nxt = buf_r >> 8;
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r  <= 1'b0;
      st_r          <= '0;
      cnt_r         <= '0;
      trl_r         <= 1'b0;
      sync_first_r  <= SYNC_FIRST_RESET;
      sync_second_r <= SYNC_SECOND_RESET;
    end else begin
      if (in_ready) begin
        hold_valid_r <= in_valid;
      end
      if (load) begin
        st_r <= st_nxt;
      end
      cnt_r <= cnt_nxt;
      trl_r <= trl_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SYNC_FIRST) begin
          sync_first_r <= cfg_data;
        end else if (cfg_index == CFG_SYNC_SECOND) begin
          sync_second_r <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    if (in_valid && in_ready) begin
      item_r.op           <= op_t'(in_op);
      item_r.channel_id   <= in_channel_id;
      item_r.frame_length <= in_frame_length;
      item_r.payload_byte <= in_payload_byte;
    end
  end

endmodule

// ===== rtl/fpks_checker.sv =====
// Port-level checks of the framed packet sender, bound to the top level.
module fpks_checker import fpks_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [7:0]           out_byte,
  input logic                 out_run_last,
  input logic                 out_frame_end,
  input logic                 cfg_valid,
  input logic                 cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
    $stable(out_run_last) && $stable(out_frame_end))
    else $error("stalled output transfer changed");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_run_last)
    else $error("frame end byte is not the last result of its item");

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !out_valid |-> in_ready)
    else $error("input stalled while output is empty");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind fletcher_framed_packet_sender fpks_checker u_fpks_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_byte      (out_byte),
  .out_run_last  (out_run_last),
  .out_frame_end (out_frame_end),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready)
);

// ===== sim/fletcher_framed_packet_sender_tb.sv =====
// Self-checking testbench for the framed packet sender: directed and random framing traffic, sync writes and stalls.
module fletcher_framed_packet_sender_tb;
  import fpks_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 80;
  localparam int SETTLE      = 12;

  typedef struct packed {
    logic [7:0] value;
    logic       run_last;
    logic       frame_end;
  } stream_byte_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_op = 1'b0;
  logic [7:0]           in_channel_id = '0;
  logic [15:0]          in_frame_length = '0;
  logic [7:0]           in_payload_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           out_byte;
  logic                 out_run_last;
  logic                 out_frame_end;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  item_t        pending_items[$];
  stream_byte_t expected_stream[$];
  stream_byte_t run_bytes[$];

  logic [7:0]  sync_first_m = SYNC_FIRST_RESET;
  logic [7:0]  sync_second_m = SYNC_SECOND_RESET;
  logic [7:0]  sum_a_m = '0;
  logic [7:0]  sum_b_m = '0;
  logic [15:0] bytes_left_m = '0;
  logic        frame_open_m = 1'b0;

  logic in_xfer = 1'b0;
  logic calm = 1'b0;
  logic long_hold_go = 1'b0;
  logic long_hold_done = 1'b0;
  int   send_gap = 0;
  int   hold_left = 0;
  int   idle_cycles = 0;

  int mismatches = 0;
  int frames_started = 0;
  int empty_frames = 0;
  int abandoned_frames = 0;
  int stray_payloads = 0;
  int bytes_checked = 0;
  int trailers_seen = 0;
  int reg_writes = 0;

  fletcher_framed_packet_sender i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_channel_id   (in_channel_id),
    .in_frame_length (in_frame_length),
    .in_payload_byte (in_payload_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_run_last    (out_run_last),
    .out_frame_end   (out_frame_end),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void push_summed(logic [7:0] b);
    stream_byte_t sb;
    sum_a_m = sum_a_m + b;
    sum_b_m = sum_b_m + sum_a_m;
    sb.value = b;
    sb.run_last = 1'b0;
    sb.frame_end = 1'b0;
    run_bytes.push_back(sb);
  endfunction

  function automatic void push_checksum();
    stream_byte_t sb;
    sb.value = sum_a_m;
    sb.run_last = 1'b0;
    sb.frame_end = 1'b0;
    run_bytes.push_back(sb);
    sb.value = sum_b_m;
    sb.frame_end = 1'b1;
    run_bytes.push_back(sb);
    frame_open_m = 1'b0;
    bytes_left_m = '0;
  endfunction

  function automatic void frame_stream_model(item_t it);
    stream_byte_t sb;
    run_bytes.delete();
    if (it.op == OP_START) begin
      frames_started++;
      if (frame_open_m) abandoned_frames++;
      sum_a_m = '0;
      sum_b_m = '0;
      push_summed(sync_first_m);
      push_summed(sync_second_m);
      push_summed(it.channel_id);
      push_summed(it.frame_length[15:8]);
      push_summed(it.frame_length[7:0]);
      if (it.frame_length == 16'h0000) begin
        empty_frames++;
        push_checksum();
      end else begin
        frame_open_m = 1'b1;
        bytes_left_m = it.frame_length;
      end
    end else begin
      if (!frame_open_m || bytes_left_m == 16'h0000) begin
        stray_payloads++;
        return;
      end
      push_summed(it.payload_byte);
      bytes_left_m = bytes_left_m - 16'd1;
      if (bytes_left_m == 16'h0000) push_checksum();
    end
    sb = run_bytes.pop_back();
    sb.run_last = 1'b1;
    run_bytes.push_back(sb);
    foreach (run_bytes[i]) expected_stream.push_back(run_bytes[i]);
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch on %s at stream byte %0d: got %02h, want %02h",
             what, bytes_checked, got, want);
    mismatches++;
  endtask

  function automatic item_t start_item(logic [7:0] ch, logic [15:0] len);
    item_t it;
    it.op = OP_START;
    it.channel_id = ch;
    it.frame_length = len;
    it.payload_byte = 8'($urandom);
    return it;
  endfunction

  function automatic item_t data_item(logic [7:0] b);
    item_t it;
    it.op = OP_PAYLOAD;
    it.channel_id = 8'($urandom);
    it.frame_length = 16'($urandom);
    it.payload_byte = b;
    return it;
  endfunction

  // sender: hold the item until transfer, idle in short bursts
  always @(negedge clk) begin
    item_t it;
    if (rst_n && (!in_valid || in_xfer)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        send_gap <= $urandom_range(0, 3);
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        in_valid <= 1'b1;
        in_op <= it.op;
        in_channel_id <= it.channel_id;
        in_frame_length <= it.frame_length;
        in_payload_byte <= it.payload_byte;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (long_hold_go && !long_hold_done) begin
      long_hold_done <= 1'b1;
      hold_left <= LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (rst_n && !calm && $urandom_range(0, 5) == 0) begin
      hold_left <= $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n;
    end
  end

  always @(posedge clk) begin
    stream_byte_t want;
    item_t        it;
    in_xfer <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        it.op = op_t'(in_op);
        it.channel_id = in_channel_id;
        it.frame_length = in_frame_length;
        it.payload_byte = in_payload_byte;
        frame_stream_model(it);
      end
      if (out_valid && out_ready) begin
        if (expected_stream.size() == 0) begin
          report_mismatch("unexpected transfer", out_byte, 8'h00);
        end else begin
          want = expected_stream.pop_front();
          if (out_byte !== want.value) report_mismatch("out_byte", out_byte, want.value);
          if (out_run_last !== want.run_last)
            report_mismatch("out_run_last", 8'(out_run_last), 8'(want.run_last));
          if (out_frame_end !== want.frame_end)
            report_mismatch("out_frame_end", 8'(out_frame_end), 8'(want.frame_end));
          if (want.frame_end) trailers_seen++;
        end
        bytes_checked++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no transfer for %0d cycles, %0d bytes still expected",
                 idle_cycles, expected_stream.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SYNC_FIRST) sync_first_m = val;
    else if (idx == CFG_SYNC_SECOND) sync_second_m = val;
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_and_settle();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_stream.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic queue_frames(input int target);
    int made;
    int len;
    int k;
    int kind;
    made = 0;
    while (made < target) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
        pending_items.push_back(start_item(8'($urandom), 16'(len)));
        repeat (len) pending_items.push_back(data_item(8'($urandom)));
        made += 1 + len;
      end else if (kind == 7) begin
        len = $urandom_range(4, 65535);
        k = $urandom_range(0, 3);
        pending_items.push_back(start_item(8'($urandom), 16'(len)));
        repeat (k) pending_items.push_back(data_item(8'($urandom)));
        made += 1 + k;
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 2)) pending_items.push_back(data_item(8'($urandom)));
      end else begin
        pending_items.push_back(start_item(8'($urandom), 16'h0000));
        made++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    pending_items.push_back(data_item(8'hFF));
    pending_items.push_back(start_item(8'h00, 16'h0000));
    pending_items.push_back(start_item(8'hFF, 16'hFFFF));
    pending_items.push_back(data_item(8'h00));
    pending_items.push_back(data_item(8'hFF));
    pending_items.push_back(start_item(8'h5B, 16'h0003));
    pending_items.push_back(data_item(8'hA5));
    pending_items.push_back(data_item(8'h5A));
    pending_items.push_back(data_item(8'hFF));
    pending_items.push_back(data_item(8'h3C));
    pending_items.push_back(start_item(8'h80, 16'h0001));
    pending_items.push_back(data_item(8'h7F));
    pending_items.push_back(start_item(8'h01, 16'h0100));
    pending_items.push_back(start_item(8'h7E, 16'h8000));
    pending_items.push_back(start_item(8'hC3, 16'h0002));
    pending_items.push_back(data_item(8'h01));
    pending_items.push_back(data_item(8'h80));
    drain_and_settle();

    write_reg(CFG_SYNC_FIRST, 8'h00);
    write_reg(CFG_SYNC_SECOND, 8'hFF);
    queue_frames(35);
    long_hold_go = 1'b1;
    drain_and_settle();

    write_reg(CFG_SYNC_FIRST, 8'hFF);
    write_reg(CFG_SYNC_SECOND, 8'h00);
    queue_frames(35);
    drain_and_settle();

    write_reg(CFG_SYNC_SECOND, 8'($urandom));
    write_reg(CFG_SYNC_FIRST, 8'($urandom));
    queue_frames(30);
    drain_and_settle();

    write_reg(CFG_SYNC_FIRST, SYNC_FIRST_RESET);
    write_reg(CFG_SYNC_SECOND, SYNC_SECOND_RESET);
    calm = 1'b1;
    queue_frames(30);
    drain_and_settle();
    repeat (20) @(posedge clk);

    if (expected_stream.size() != 0) begin
      $display("%0d stream bytes never arrived", expected_stream.size());
      mismatches++;
    end
    $display("covered %0d frames (%0d empty, %0d abandoned), %0d stray payloads dropped",
             frames_started, empty_frames, abandoned_frames, stray_payloads);
    $display("checked %0d stream bytes and %0d checksum trailers over %0d register writes",
             bytes_checked, trailers_seen, reg_writes);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
